// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int RANK_BITS  = IDX_BITS;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CFG_BITS   = 5;
  localparam int IN_BITS    = KEY_BITS + VALUE_BITS;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(16);

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef struct packed {
    logic cap_in;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
  } dp_sts_t;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
module lkvc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  lkvc_pkg::dp_sts_t    sts,
  output lkvc_pkg::ctrl_cmd_t  cmd
);
  import lkvc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       upd_ok;
  logic       accept;

  assign out_free   = !out_valid_r || out_tready;
  assign upd_ok     = (state_r == ST_UPDATE) && (!sts.is_get || out_free);
  assign in_tready  = (state_r == ST_IDLE) || upd_ok;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign cmd.cap_in = accept;
  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.update = upd_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_ok) state_nxt = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (upd_ok && sts.is_get) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/lkvc_dp.sv =====
module lkvc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lkvc_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic                                in_command,
  input  logic [lkvc_pkg::KEY_BITS-1:0]       in_key,
  input  logic [lkvc_pkg::VALUE_BITS-1:0]     in_put_value,
  input  lkvc_pkg::ctrl_cmd_t                 cmd,
  output lkvc_pkg::dp_sts_t                   sts,
  output logic                                out_hit,
  output logic [lkvc_pkg::VALUE_BITS-1:0]     out_read_value
);
  import lkvc_pkg::*;

  logic [CFG_BITS-1:0]   active_r;
  logic                  command_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] put_value_r;

  logic                  valid_r [ENTRIES];
  logic [RANK_BITS-1:0]  rank_r  [ENTRIES];
  logic [KEY_BITS-1:0]   ekey_r  [ENTRIES];
  logic [VALUE_BITS-1:0] evalue_r[ENTRIES];

  logic                  hit_r;
  logic [IDX_BITS-1:0]   found_r;
  logic                  has_empty_r;
  logic [IDX_BITS-1:0]   empty_r;
  logic [IDX_BITS-1:0]   victim_r;
  logic [VALUE_BITS-1:0] rd_value_r;

  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_value_r;

  logic [CNT_BITS-1:0]   act_cnt;
  logic [ENTRIES-1:0]    in_use;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    empty;
  logic [IDX_BITS-1:0]   found_idx;
  logic [IDX_BITS-1:0]   empty_idx;

  logic                  node_ok [2*ENTRIES];
  logic [RANK_BITS-1:0]  node_rk [2*ENTRIES];
  logic [IDX_BITS-1:0]   node_ix [2*ENTRIES];

  logic [IDX_BITS-1:0]   tgt;
  logic                  fill_mode;
  logic                  rank_upd;
  logic                  is_put;
  logic [RANK_BITS-1:0]  old_rank;

  assign sts.is_get     = (command_r == CMD_GET);
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  // active count clamp: zero acts as one, beyond the entry count acts as full
  always_comb begin
    priority if (active_r == '0) begin
      act_cnt = CNT_BITS'(1);
    end else if (CNT_BITS'(active_r) > CNT_BITS'(ENTRIES)) begin
      act_cnt = CNT_BITS'(ENTRIES);
    end else begin
      act_cnt = CNT_BITS'(active_r);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i] = CNT_BITS'(i) < act_cnt;
      match[i]  = in_use[i] && valid_r[i] && (ekey_r[i] == key_r);
      empty[i]  = in_use[i] && !valid_r[i];
    end
  end

  // lowest index wins
  always_comb begin
    found_idx = '0;
    empty_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) found_idx = IDX_BITS'(i);
      if (empty[i]) empty_idx = IDX_BITS'(i);
    end
  end

  // oldest active entry, comparator tree with left preference on ties
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      node_ok[ENTRIES + i] = in_use[i];
      node_rk[ENTRIES + i] = rank_r[i];
      node_ix[ENTRIES + i] = IDX_BITS'(i);
    end
    node_ok[0] = 1'b0;
    node_rk[0] = '0;
    node_ix[0] = '0;
    for (int k = ENTRIES - 1; k >= 1; k--) begin
      if (node_ok[2*k] && (!node_ok[2*k+1] || node_rk[2*k] >= node_rk[2*k+1])) begin
        node_ok[k] = 1'b1;
        node_rk[k] = node_rk[2*k];
        node_ix[k] = node_ix[2*k];
      end else begin
        node_ok[k] = node_ok[2*k+1];
        node_rk[k] = node_rk[2*k+1];
        node_ix[k] = node_ix[2*k+1];
      end
    end
  end

  always_comb begin
    priority if (hit_r) begin
      tgt = found_r;
    end else if (has_empty_r) begin
      tgt = empty_r;
    end else begin
      tgt = victim_r;
    end
  end

  assign is_put    = (command_r == CMD_PUT);
  assign fill_mode = !hit_r && has_empty_r;
  assign rank_upd  = cmd.update && (is_put || hit_r);
  assign old_rank  = rank_r[tgt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      command_r   <= in_command;
      key_r       <= in_key;
      put_value_r <= in_put_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r       <= |match;
      found_r     <= found_idx;
      has_empty_r <= |empty;
      empty_r     <= empty_idx;
      victim_r    <= node_ix[1];
      rd_value_r  <= evalue_r[found_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else if (rank_upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_BITS'(i) == tgt) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && (fill_mode || rank_r[i] < old_rank)) begin
          rank_r[i] <= RANK_BITS'(rank_r[i] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && is_put) begin
      ekey_r[tgt]   <= key_r;
      evalue_r[tgt] <= put_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !is_put) begin
      out_hit_r   <= hit_r;
      out_value_r <= hit_r ? rd_value_r : '0;
    end
  end

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// channel | handshake             | payload
// in      | in_tvalid  in_tready  | tdata: key, put_value; tuser: command
// out     | out_tvalid out_tready | tdata: read_value; tuser: hit
// cfg     | cfg_wr_en             | cfg_wr_data: active_entries
//
// each item passes a lookup state (parallel key compare, empty and lru search), then an
// update state (rank, key and value write); the next item is taken in the update state
// a get waits in the update state while the output register holds an untaken item
// puts give no output item
// synchronous active-low reset empties the cache and sets active_entries to 16
module lru_key_value_cache_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lkvc_pkg::CFG_BITS-1:0]        cfg_wr_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lkvc_pkg::IN_BITS-1:0]         in_tdata,   // key, put_value
  input  logic                                 in_tuser,   // command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lkvc_pkg::VALUE_BITS-1:0]      out_tdata,  // read_value
  output logic                                 out_tuser   // hit
);
  import lkvc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lkvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lkvc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_tuser),
    .in_key         (in_tdata[KEY_BITS-1:0]),
    .in_put_value   (in_tdata[IN_BITS-1:KEY_BITS]),
    .cmd            (cmd),
    .sts            (sts),
    .out_hit        (out_tuser),
    .out_read_value (out_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !(in_tvalid && in_tready))
    else $error("item accepted in lookup cycle");

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("output item without matching input item");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("miss returns nonzero value");

  a_lookup_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> !cmd.lookup)
    else $error("back to back lookup cycles");

endmodule
